FILE: hw/rtl/ttms_pkg.sv
// Shared types, character codes and helpers for the time tag to milliseconds block.
package ttms_pkg;

    localparam int MAX_PARTS       = 3;
    localparam int FRACTION_DIGITS = 3;
    localparam int WIDE_W          = 42;

    localparam logic [30:0] SAT31 = 31'h7FFF_FFFF;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    typedef enum logic [2:0] {
        PH_INT,
        PH_AFTER,
        PH_FRAC,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [30:0] seconds;
        logic [9:0]  frac_ms;
        logic        ok;
    } mid_t;

    function automatic logic [30:0] sat31(input logic [WIDE_W-1:0] v);
        logic [30:0] r;
        if (v > {{(WIDE_W-31){1'b0}}, SAT31}) begin
            r = SAT31;
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/ttms_parse.sv
// Character parser: time text state and the seconds/fraction summary on a terminator.
module ttms_parse (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step_en,
    input  logic [7:0]     character,
    input  logic           terminator,
    output ttms_pkg::mid_t result
);

    ttms_pkg::phase_t phase_reg, phase_next;
    logic [30:0] part_value_reg, part_value_next;
    logic [30:0] seconds_total_reg, seconds_total_next;
    logic [1:0]  parts_seen_reg, parts_seen_next;
    logic        digit_seen_reg, digit_seen_next;
    logic [9:0]  fraction_value_reg, fraction_value_next;
    logic [1:0]  fraction_count_reg, fraction_count_next;

    logic        is_digit;
    logic        is_point;
    logic [3:0]  digit;
    logic [30:0] part_acc;
    logic [30:0] fin_total;
    logic [1:0]  fin_parts;
    logic [30:0] total_f;
    logic [1:0]  parts_f;
    logic [9:0]  frac_pad;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= ttms_pkg::PH_INT;
            part_value_reg     <= '0;
            seconds_total_reg  <= '0;
            parts_seen_reg     <= '0;
            digit_seen_reg     <= 1'b0;
            fraction_value_reg <= '0;
            fraction_count_reg <= '0;
        end else if (step_en) begin
            phase_reg          <= phase_next;
            part_value_reg     <= part_value_next;
            seconds_total_reg  <= seconds_total_next;
            parts_seen_reg     <= parts_seen_next;
            digit_seen_reg     <= digit_seen_next;
            fraction_value_reg <= fraction_value_next;
            fraction_count_reg <= fraction_count_next;
        end
    end

    always_comb begin
        is_digit  = (character >= ttms_pkg::CHAR_ZERO) && (character <= ttms_pkg::CHAR_NINE);
        is_point  = (character == ttms_pkg::CHAR_DOT) || (character == ttms_pkg::CHAR_COMMA);
        digit     = 4'(character - ttms_pkg::CHAR_ZERO);
        part_acc  = ttms_pkg::sat31(
                        {{(ttms_pkg::WIDE_W-31){1'b0}}, part_value_reg} * 42'd10
                        + {{(ttms_pkg::WIDE_W-4){1'b0}}, digit});
        fin_total = ttms_pkg::sat31(
                        {{(ttms_pkg::WIDE_W-31){1'b0}}, seconds_total_reg} * 42'd60
                        + {{(ttms_pkg::WIDE_W-31){1'b0}}, part_value_reg});
        fin_parts = (parts_seen_reg < 2'd3) ? parts_seen_reg + 2'd1 : parts_seen_reg;

        phase_next          = phase_reg;
        part_value_next     = part_value_reg;
        seconds_total_next  = seconds_total_reg;
        parts_seen_next     = parts_seen_reg;
        digit_seen_next     = digit_seen_reg;
        fraction_value_next = fraction_value_reg;
        fraction_count_next = fraction_count_reg;

        if (terminator) begin
            phase_next          = ttms_pkg::PH_INT;
            part_value_next     = '0;
            seconds_total_next  = '0;
            parts_seen_next     = '0;
            digit_seen_next     = 1'b0;
            fraction_value_next = '0;
            fraction_count_next = '0;
        end else begin
            unique case (phase_reg)
                ttms_pkg::PH_INT: begin
                    if (is_digit) begin
                        part_value_next = part_acc;
                        digit_seen_next = 1'b1;
                    end else if (digit_seen_reg) begin
                        seconds_total_next = fin_total;
                        parts_seen_next    = fin_parts;
                        part_value_next    = '0;
                        digit_seen_next    = 1'b0;
                        if (character == ttms_pkg::CHAR_COLON) begin
                            phase_next = (fin_parts < 2'(ttms_pkg::MAX_PARTS))
                                       ? ttms_pkg::PH_INT : ttms_pkg::PH_AFTER;
                        end else begin
                            phase_next = is_point ? ttms_pkg::PH_FRAC : ttms_pkg::PH_DONE;
                        end
                    end else if ((parts_seen_reg != 2'd0) && is_point) begin
                        phase_next = ttms_pkg::PH_FRAC;
                    end else begin
                        phase_next = ttms_pkg::PH_DONE;
                    end
                end
                ttms_pkg::PH_AFTER: begin
                    phase_next = is_point ? ttms_pkg::PH_FRAC : ttms_pkg::PH_DONE;
                end
                ttms_pkg::PH_FRAC: begin
                    if (is_digit &&
                        (fraction_count_reg < 2'(ttms_pkg::FRACTION_DIGITS))) begin
                        fraction_value_next = 10'(fraction_value_reg * 10'd10)
                                            + {6'b0, digit};
                        fraction_count_next = fraction_count_reg + 2'd1;
                    end else begin
                        phase_next = ttms_pkg::PH_DONE;
                    end
                end
                ttms_pkg::PH_DONE: begin
                    phase_next = ttms_pkg::PH_DONE;
                end
                default: begin
                    phase_next = ttms_pkg::PH_DONE;
                end
            endcase
        end
    end

    always_comb begin
        if ((phase_reg == ttms_pkg::PH_INT) && digit_seen_reg) begin
            total_f = fin_total;
            parts_f = fin_parts;
        end else begin
            total_f = seconds_total_reg;
            parts_f = parts_seen_reg;
        end

        case (fraction_count_reg)
            2'd1:    frac_pad = 10'(fraction_value_reg * 10'd100);
            2'd2:    frac_pad = 10'(fraction_value_reg * 10'd10);
            2'd3:    frac_pad = fraction_value_reg;
            default: frac_pad = '0;
        endcase

        result.ok      = (parts_f != 2'd0);
        result.seconds = result.ok ? total_f : '0;
        result.frac_ms = result.ok ? frac_pad : '0;
    end

endmodule

FILE: hw/rtl/time_tag_to_milliseconds.sv
// Top level of the time tag to milliseconds converter.
// Usage:
//   The input channel (s_valid/s_ready) carries one character of a time text
//   per item in s_character; an item with s_terminator high ends the text and
//   its character is ignored. Texts read as s, m:s or h:m:s with an optional
//   '.' or ',' fraction of up to three digits.
//   The result channel (m_valid/m_ready) carries one item per terminator:
//   m_time_ms (saturated at 2^31-1) and m_parse_ok; character items give none.
//   A terminator's result passes the input register, the parse stage register
//   and the output register behind the x1000 scale before it shows on m_.
//   Throughput: one item per cycle while s_ready is high; the parse step works
//   on the input register, and there is no iteration anywhere.
//   When the receiver stalls, the result and parse stage registers fill, and
//   s_ready drops only once a terminator can no longer move forward;
//   character items keep flowing until then.
//   Reset (aresetn low, synchronous) empties all stages and returns the parser
//   to the start of a text.
module time_tag_to_milliseconds (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_terminator,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [30:0] m_time_ms,
    output logic        m_parse_ok
);

    logic           in_valid_reg;
    logic [7:0]     in_char_reg;
    logic           in_term_reg;
    logic           mid_valid_reg;
    ttms_pkg::mid_t mid_reg;
    logic           out_valid_reg;
    logic [30:0]    out_time_reg;
    logic           out_ok_reg;

    ttms_pkg::mid_t parse_result;
    logic           out_free;
    logic           mid_adv;
    logic           mid_free;
    logic           step_en;
    logic [30:0]    time_scaled;

    ttms_parse u_parse (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .character  (in_char_reg),
        .terminator (in_term_reg),
        .result     (parse_result)
    );

    always_comb begin
        out_free    = !out_valid_reg || m_ready;
        mid_adv     = mid_valid_reg && out_free;
        mid_free    = !mid_valid_reg || mid_adv;
        step_en     = in_valid_reg && (!in_term_reg || mid_free);
        s_ready     = !in_valid_reg || step_en;
        time_scaled = ttms_pkg::sat31(
                          {{(ttms_pkg::WIDE_W-31){1'b0}}, mid_reg.seconds} * 42'd1000
                          + {{(ttms_pkg::WIDE_W-10){1'b0}}, mid_reg.frac_ms});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (mid_free) begin
                mid_valid_reg <= step_en && in_term_reg;
            end
            if (out_free) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_char_reg <= s_character;
            in_term_reg <= s_terminator;
        end
        if (step_en && in_term_reg) begin
            mid_reg <= parse_result;
        end
        if (mid_adv) begin
            out_time_reg <= time_scaled;
            out_ok_reg   <= mid_reg.ok;
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_time_ms  = out_time_reg;
    assign m_parse_ok = out_ok_reg;

endmodule

FILE: verif/ttms_duration_checker.sv
// Checker for the time tag converter: predicts each duration and compares the result channel.
`timescale 1ns / 1ps

module ttms_duration_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_terminator,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [30:0] m_time_ms,
    input  logic        m_parse_ok,
    output int          mismatch_count,
    output int          durations_pending,
    output int          durations_checked
);

    typedef struct packed {
        logic [30:0] ms;
        logic        ok;
    } duration_t;

    duration_t expected_durations[$];

    ttms_pkg::phase_t phase;
    logic [30:0] part_value;
    logic [30:0] seconds_total;
    logic [1:0]  parts_seen;
    logic        digit_seen;
    logic [9:0]  fraction_value;
    logic [1:0]  fraction_count;

    function automatic logic [30:0] clip31(input longint unsigned v);
        logic [30:0] r;
        if (v > 64'(ttms_pkg::SAT31)) begin
            r = ttms_pkg::SAT31;
        end else begin
            r = v[30:0];
        end
        return r;
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= ttms_pkg::CHAR_ZERO) && (ch <= ttms_pkg::CHAR_NINE);
    endfunction

    function automatic logic is_point(input logic [7:0] ch);
        return (ch == ttms_pkg::CHAR_DOT) || (ch == ttms_pkg::CHAR_COMMA);
    endfunction

    task automatic clear_text();
        phase          = ttms_pkg::PH_INT;
        part_value     = '0;
        seconds_total  = '0;
        parts_seen     = '0;
        digit_seen     = 1'b0;
        fraction_value = '0;
        fraction_count = '0;
    endtask

    task automatic fold_part();
        seconds_total = clip31(64'(seconds_total) * 60 + 64'(part_value));
        if (parts_seen < 2'd3) begin
            parts_seen = parts_seen + 2'd1;
        end
        part_value = '0;
        digit_seen = 1'b0;
    endtask

    task automatic absorb_character(input logic [7:0] ch);
        case (phase)
            ttms_pkg::PH_INT: begin
                if (is_digit(ch)) begin
                    part_value = clip31(64'(part_value) * 10
                                        + 64'(ch - ttms_pkg::CHAR_ZERO));
                    digit_seen = 1'b1;
                end else if (digit_seen) begin
                    fold_part();
                    if (ch == ttms_pkg::CHAR_COLON) begin
                        phase = (parts_seen < ttms_pkg::MAX_PARTS)
                              ? ttms_pkg::PH_INT : ttms_pkg::PH_AFTER;
                    end else begin
                        phase = is_point(ch) ? ttms_pkg::PH_FRAC : ttms_pkg::PH_DONE;
                    end
                end else if (parts_seen != 2'd0 && is_point(ch)) begin
                    phase = ttms_pkg::PH_FRAC;
                end else begin
                    phase = ttms_pkg::PH_DONE;
                end
            end
            ttms_pkg::PH_AFTER: begin
                phase = is_point(ch) ? ttms_pkg::PH_FRAC : ttms_pkg::PH_DONE;
            end
            ttms_pkg::PH_FRAC: begin
                if (is_digit(ch) && fraction_count < ttms_pkg::FRACTION_DIGITS) begin
                    fraction_value = fraction_value * 10'd10
                                   + 10'(ch - ttms_pkg::CHAR_ZERO);
                    fraction_count = fraction_count + 2'd1;
                end else begin
                    phase = ttms_pkg::PH_DONE;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic close_text(output duration_t d);
        logic [9:0] frac;
        int         n;
        if (phase == ttms_pkg::PH_INT && digit_seen) begin
            fold_part();
        end
        if (parts_seen == 2'd0) begin
            d.ms = '0;
            d.ok = 1'b0;
        end else begin
            frac = fraction_value;
            for (n = fraction_count; n < 3; n++) begin
                frac = frac * 10'd10;
            end
            d.ms = clip31(64'(seconds_total) * 1000 + 64'(frac));
            d.ok = 1'b1;
        end
        clear_text();
    endtask

    always @(posedge aclk) begin : watch
        duration_t want;
        if (!aresetn) begin
            clear_text();
            expected_durations.delete();
            mismatch_count    = 0;
            durations_checked = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_durations.size() == 0) begin
                    $error("unexpected result: time_ms %0d, parse_ok %0d",
                           m_time_ms, m_parse_ok);
                    mismatch_count++;
                end else begin
                    want = expected_durations.pop_front();
                    if (m_time_ms !== want.ms) begin
                        $error("time_ms: expected %0d, actual %0d", want.ms, m_time_ms);
                        mismatch_count++;
                    end
                    if (m_parse_ok !== want.ok) begin
                        $error("parse_ok: expected %0d, actual %0d", want.ok, m_parse_ok);
                        mismatch_count++;
                    end
                    durations_checked++;
                end
            end
            if (s_valid && s_ready) begin
                if (s_terminator) begin
                    close_text(want);
                    expected_durations.push_back(want);
                end else begin
                    absorb_character(s_character);
                end
            end
        end
        durations_pending = expected_durations.size();
    end

endmodule

FILE: verif/time_tag_to_milliseconds_tb.sv
// Testbench top for the time tag converter: drives time texts and gives the verdict.
`timescale 1ns / 1ps

module time_tag_to_milliseconds_tb;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_character  = 8'h00;
    logic        s_terminator = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [30:0] m_time_ms;
    logic        m_parse_ok;

    int mismatch_count;
    int durations_pending;
    int durations_checked;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int texts_sent     = 0;

    int idle_mix[4]  = '{0, 61, 0, 33};
    int stall_mix[4] = '{0, 0, 61, 33};

    logic [7:0] text_bytes[$];

    time_tag_to_milliseconds dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_character  (s_character),
        .s_terminator (s_terminator),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_time_ms    (m_time_ms),
        .m_parse_ok   (m_parse_ok)
    );

    ttms_duration_checker checker_i (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_character       (s_character),
        .s_terminator      (s_terminator),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_time_ms         (m_time_ms),
        .m_parse_ok        (m_parse_ok),
        .mismatch_count    (mismatch_count),
        .durations_pending (durations_pending),
        .durations_checked (durations_checked)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready = aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    task automatic send_item(input logic [7:0] ch, input logic term);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_character  = ch;
        s_terminator = term;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_chars(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++) begin
            send_item(txt[i], 1'b0);
        end
    endtask

    task automatic end_text();
        send_item(8'($urandom_range(0, 255)), 1'b1);
        texts_sent++;
    endtask

    task automatic push_number(input int digits);
        int k;
        for (k = 0; k < digits; k++) begin
            text_bytes.push_back(ttms_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic build_text();
        int n_parts;
        int p;
        int r;
        text_bytes.delete();
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(0, 6)) text_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            n_parts = $urandom_range(1, 3);
            for (p = 0; p < n_parts; p++) begin
                if (p > 0) begin
                    text_bytes.push_back(ttms_pkg::CHAR_COLON);
                end
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    push_number($urandom_range(7, 12));
                end else if (r < 12) begin
                    push_number($urandom_range(3, 6));
                end else if (r < 15 && p > 0) begin
                    push_number(0);
                end else begin
                    push_number($urandom_range(1, 2));
                end
            end
            if ($urandom_range(0, 99) < 10) begin
                text_bytes.push_back(ttms_pkg::CHAR_COLON);
            end
            if ($urandom_range(0, 99) < 50) begin
                text_bytes.push_back($urandom_range(0, 1) ? ttms_pkg::CHAR_DOT
                                                           : ttms_pkg::CHAR_COMMA);
                push_number($urandom_range(0, 5));
            end
            if ($urandom_range(0, 99) < 25) begin
                repeat ($urandom_range(1, 3)) text_bytes.push_back(8'($urandom_range(0, 255)));
            end
            if (text_bytes.size() > 0 && $urandom_range(0, 99) < 5) begin
                text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom_range(0, 255));
            end
        end
    endtask

    task automatic drain_results();
        s_valid = 1'b0;
        while (durations_pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin : stimulus
        int mix;
        int target;
        int i;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        end_text();
        send_chars(":");
        end_text();
        send_chars("1:2:3:.5");
        end_text();
        send_chars("7:,25x");
        end_text();
        send_chars("9.1234");
        end_text();
        send_chars("4");
        send_item(8'h00, 1'b0);
        send_chars("5");
        end_text();
        send_item(8'hFF, 1'b0);
        end_text();
        drain_results();

        for (mix = 0; mix < 4; mix++) begin
            send_idle_pct  = idle_mix[mix];
            recv_stall_pct = stall_mix[mix];
            target = items_sent + 150;
            while (items_sent < target) begin
                build_text();
                for (i = 0; i < text_bytes.size(); i++) begin
                    send_item(text_bytes[i], 1'b0);
                end
                end_text();
            end
            drain_results();
        end

        repeat (8) @(negedge aclk);
        $display("covered %0d items in %0d texts over four idle/stall mixes, %0d durations compared",
                 items_sent, texts_sent, durations_checked);
        if (mismatch_count == 0 && durations_pending == 0) begin
            $display("time_tag_to_milliseconds_tb passed");
        end else begin
            $display("time_tag_to_milliseconds_tb failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("time_tag_to_milliseconds_tb failed");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ttms_pkg.sv
hw/rtl/ttms_parse.sv
hw/rtl/time_tag_to_milliseconds.sv
verif/ttms_duration_checker.sv
verif/time_tag_to_milliseconds_tb.sv
